>>> sv/car_following_accel_min_top_assert.svh
// Assertion macros shared by the checker of car_following_accel_min_top.
// No dependencies.
`ifndef CAR_FOLLOWING_ACCEL_MIN_TOP_ASSERT_SVH
`define CAR_FOLLOWING_ACCEL_MIN_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CFA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> sv/cfa_pkg.sv
// Package for the car-following acceleration block: widths, types, clamp codes.
// No dependencies.
`timescale 1ns / 1ps
package cfa_pkg;
	localparam int VW = 32;
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [VW-1:0] Q_ONE = VW'(65536);
	localparam logic [2:0] CFG_MAX_ACCEL = 3'd0;
	localparam logic [2:0] CFG_MAX_DECEL = 3'd1;
	localparam logic [2:0] CFG_JAM = 3'd2;
	localparam logic [2:0] CFG_HEADWAY = 3'd3;
	localparam logic [2:0] CFG_INV_VMAX = 3'd4;
	localparam logic [2:0] CFG_INV_BRAKE = 3'd5;
	localparam logic [1:0] CLAMP_NONE = 2'd0;
	localparam logic [1:0] CLAMP_MAX = 2'd1;
	localparam logic [1:0] CLAMP_MIN = 2'd2;

	typedef struct packed {
		logic [30:0] own_velocity;
		logic signed [31:0] leader_distance;
		logic signed [31:0] leader_velocity;
		logic has_leader;
		logic last_leader;
		logic asleep;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] decided_accel;
		logic [1:0] clamp_status;
	} out_item_t;

	typedef struct packed {
		logic [30:0] max_accel;
		logic signed [31:0] max_decel;
		logic [30:0] jam_distance;
		logic [30:0] desired_headway;
		logic [31:0] inv_v_max;
		logic [31:0] inv_brake_term;
	} cfg_t;

	// Saturate a 66-bit signed value to VW bits.
	function automatic logic signed [VW-1:0] sat66(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'(VMAX);
		lo = 66'(VMIN);
		if (x > hi) return VMAX;
		if (x < lo) return VMIN;
		return VW'(x);
	endfunction
endpackage

>>> sv/cfa_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on cfa_pkg.
`timescale 1ns / 1ps
interface cfa_in_if;
	logic valid;
	logic ready;
	cfa_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cfa_out_if;
	logic valid;
	logic ready;
	cfa_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/cfa_front.sv
// Front end: accepts input items into a two-entry queue toward the back end.
// Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cfa_pkg::in_item_t in_data,
	output logic q_valid,
	input logic q_pop,
	output cfa_pkg::in_item_t q_data
);
	cfa_pkg::in_item_t mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop && q_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end
endmodule

>>> sv/cfa_mul.sv
// Shared sequential multiplier: product of the 32-bit magnitudes of two 33-bit signed
// operands, registered, shifted, rounded toward zero and saturated. Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [32:0] a,
	input logic signed [32:0] b,
	input logic sh32,
	output logic done,
	output logic signed [31:0] res
);
	logic [31:0] ma_q;
	logic [31:0] mb_q;
	logic neg_q;
	logic sh_q;
	logic busy_q;
	logic [63:0] prod_s1;
	logic [32:0] abs_a;
	logic [32:0] abs_b;
	logic [63:0] shv;

	assign abs_a = a[32] ? 33'(-a) : 33'(a);
	assign abs_b = b[32] ? 33'(-b) : 33'(b);
	assign shv = sh_q ? (prod_s1 >> 32) : (prod_s1 >> 16);

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q <= abs_a[31:0];
			mb_q <= abs_b[31:0];
			neg_q <= a[32] ^ b[32];
			sh_q <= sh32;
		end
		prod_s1 <= ma_q * mb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			busy_q <= start;
			done <= busy_q;
		end
	end

	always_comb begin
		if (neg_q) begin
			if (shv > 64'h8000_0000) res = cfa_pkg::VMIN;
			else res = 32'(-shv);
		end else begin
			if (shv > 64'h7FFF_FFFF) res = cfa_pkg::VMAX;
			else res = 32'(shv);
		end
	end
endmodule

>>> sv/cfa_div.sv
// Restoring divider for s/d in Q16.16, one quotient bit per cycle, saturated.
// A divisor at or below zero gives the maximum value. Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [31:0] num,
	input logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] res
);
	logic [47:0] q_q;
	logic [31:0] r_q;
	logic [31:0] d_q;
	logic neg_q;
	logic zero_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;
	logic [32:0] absn;

	assign absn = num[31] ? 33'(-33'(num)) : 33'(num);
	assign trial = {r_q, q_q[47]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= {absn[31:0], 16'd0};
			r_q <= '0;
			d_q <= den;
			neg_q <= num[31];
			zero_q <= (den <= 0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= {r_q[30:0], q_q[47]};
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) res = cfa_pkg::VMAX;
		else if (neg_q) res = (q_q > 48'h8000_0000) ? cfa_pkg::VMIN : 32'(-q_q);
		else res = (q_q > 48'h7FFF_FFFF) ? cfa_pkg::VMAX : 32'(q_q);
	end
endmodule

>>> sv/cfa_back.sv
// Back end: a sequencer that evaluates one item on the shared multiplier and divider,
// updates the running minimum; an awake last item emits it clamped. Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_back (
	input logic clk,
	input logic arst_n,
	input cfa_pkg::cfg_t cfg,
	input logic q_valid,
	output logic q_pop,
	input cfa_pkg::in_item_t q_data,
	output logic out_valid,
	input logic out_ready,
	output cfa_pkg::out_item_t out_data
);
	localparam logic [4:0] S_IDLE = 5'd0, S_R = 5'd1, S_FREE = 5'd2, S_R2 = 5'd3,
		S_R4 = 5'd4, S_VDV = 5'd5, S_VT = 5'd6, S_BRK = 5'd7, S_DIV = 5'd8,
		S_QQ = 5'd9, S_CAND = 5'd10, S_FIN = 5'd11;
	logic [4:0] st_q;
	logic wait_q;
	cfa_pkg::in_item_t it_q;
	logic signed [31:0] r_q, r2_q, c1_q, vdv_q, s_q, min_q, mres;
	logic start_q;
	logic mstart, mdone, dstart, ddone, sh32;
	logic signed [32:0] ma, mb;
	logic signed [31:0] dres, a_s, vt_q;
	logic signed [65:0] tmp;
	logic signed [31:0] accv;
	logic [1:0] stat;
	logic emit;
	logic fin_hold;

	assign a_s = 32'(cfg.max_accel);
	assign q_pop = (st_q == S_IDLE) && q_valid;

	// A result is written into the output register unless the previous one still waits.
	assign emit = (st_q == S_FIN) && it_q.last_leader && !it_q.asleep;
	assign fin_hold = emit && out_valid && !out_ready;

	cfa_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .sh32,
		.done(mdone), .res(mres));
	cfa_div u_div (.clk, .arst_n, .start(dstart), .num(s_q), .den(it_q.leader_distance),
		.done(ddone), .res(dres));

	always_comb begin
		ma = '0;
		mb = '0;
		sh32 = 1'b0;
		tmp = '0;
		case (st_q)
			S_R: begin
				ma = 33'(it_q.own_velocity); mb = {1'b0, cfg.inv_v_max}; sh32 = 1'b1;
			end
			S_FREE: begin
				tmp = 66'(cfa_pkg::Q_ONE) - 66'(r_q);
				ma = 33'(a_s); mb = 33'(cfa_pkg::sat66(tmp));
			end
			S_R2: begin ma = 33'(r_q); mb = 33'(r_q); end
			S_R4: begin ma = 33'(r2_q); mb = 33'(r2_q); end
			S_VDV: begin
				tmp = 66'(signed'({1'b0, it_q.own_velocity})) - 66'(it_q.leader_velocity);
				ma = 33'(it_q.own_velocity); mb = 33'(cfa_pkg::sat66(tmp));
			end
			S_VT: begin ma = 33'(it_q.own_velocity); mb = 33'(cfg.desired_headway); end
			S_BRK: begin ma = 33'(vdv_q); mb = {1'b0, cfg.inv_brake_term}; sh32 = 1'b1; end
			S_QQ: begin ma = 33'(dres); mb = 33'(dres); end
			S_CAND: begin ma = 33'(a_s); mb = 33'(c1_q < s_q ? c1_q : s_q); end
			default: ;
		endcase
	end

	always_comb begin
		accv = min_q;
		stat = cfa_pkg::CLAMP_NONE;
		if (min_q > a_s) begin
			accv = a_s;
			stat = cfa_pkg::CLAMP_MAX;
		end else if (min_q < cfg.max_decel) begin
			accv = cfg.max_decel;
			stat = cfa_pkg::CLAMP_MIN;
		end
	end

	assign mstart = !wait_q && (st_q inside {S_R, S_FREE, S_R2, S_R4, S_VDV, S_VT, S_BRK,
		S_QQ, S_CAND});
	assign dstart = (st_q == S_DIV) && !wait_q;

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_data;
		if (mdone) begin
			case (st_q)
				S_R: r_q <= mres;
				S_R2: r2_q <= mres;
				S_R4: c1_q <= cfa_pkg::sat66(66'(cfa_pkg::Q_ONE) - 66'(mres));
				S_VDV: vdv_q <= mres;
				S_VT: vt_q <= mres;
				S_BRK: s_q <= cfa_pkg::sat66(66'(cfg.jam_distance) + 66'(vt_q) + 66'(mres));
				S_QQ: s_q <= cfa_pkg::sat66(66'(cfa_pkg::Q_ONE) - 66'(mres));
				default: ;
			endcase
		end
		if (st_q == S_FREE && mdone) min_q <= mres;
		if (st_q == S_CAND && mdone && mres < min_q) min_q <= mres;
		if (emit && !fin_hold) begin
			out_data.decided_accel <= accv;
			out_data.clamp_status <= stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wait_q <= 1'b0;
			start_q <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			if (emit && !fin_hold) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (mstart || dstart) wait_q <= 1'b1;
			case (st_q)
				S_IDLE: if (q_pop) st_q <= S_R;
				S_FIN: if (!fin_hold) begin
					start_q <= it_q.last_leader;
					st_q <= S_IDLE;
				end
				S_DIV: if (ddone) begin wait_q <= 1'b0; st_q <= S_QQ; end
				default: if (mdone) begin
					wait_q <= 1'b0;
					case (st_q)
						S_R: st_q <= start_q ? S_FREE : (it_q.has_leader ? S_R2 : S_FIN);
						S_FREE: st_q <= it_q.has_leader ? S_R2 : S_FIN;
						S_R2: st_q <= S_R4;
						S_R4: st_q <= S_VDV;
						S_VDV: st_q <= S_VT;
						S_VT: st_q <= S_BRK;
						S_BRK: st_q <= S_DIV;
						S_QQ: st_q <= S_CAND;
						default: st_q <= S_FIN;
					endcase
				end
			endcase
		end
	end
endmodule

>>> sv/car_following_accel_min_top.sv
// Each item's products run one after another on the shared multiplier; a leader item
// adds the divide and the products around it, and an item that opens a run adds the
// free-flow product. A result waits in the final state while the previous one still waits.
// One item is in the back end at a time; the two-entry front queue takes new items meanwhile.
// Reset: asynchronous, active low; registers go to their listed defaults, next item opens a run.
`timescale 1ns / 1ps
module car_following_accel_min_top (
	input logic clk,
	input logic arst_n,
	cfa_in_if.sink in_ch,
	cfa_out_if.source out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	cfa_pkg::cfg_t cfg_q;
	logic qv, qpop;
	cfa_pkg::in_item_t qd;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_accel <= 31'd98304;
			cfg_q.max_decel <= -32'sd196608;
			cfg_q.jam_distance <= 31'd131072;
			cfg_q.desired_headway <= 31'd98304;
			cfg_q.inv_v_max <= 32'd257698037;
			cfg_q.inv_brake_term <= 32'd1012331924;
		end else if (cfg_we) begin
			case (cfg_index)
				cfa_pkg::CFG_MAX_ACCEL: cfg_q.max_accel <= cfg_data[30:0];
				cfa_pkg::CFG_MAX_DECEL: cfg_q.max_decel <= cfg_data;
				cfa_pkg::CFG_JAM: cfg_q.jam_distance <= cfg_data[30:0];
				cfa_pkg::CFG_HEADWAY: cfg_q.desired_headway <= cfg_data[30:0];
				cfa_pkg::CFG_INV_VMAX: cfg_q.inv_v_max <= cfg_data;
				cfa_pkg::CFG_INV_BRAKE: cfg_q.inv_brake_term <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front queue decouples acceptance from the sequencer in the back end.
	cfa_front u_front (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(in_ch.data), .q_valid(qv), .q_pop(qpop), .q_data(qd));

	cfa_back u_back (.clk, .arst_n, .cfg(cfg_q), .q_valid(qv), .q_pop(qpop), .q_data(qd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

>>> sv/cfa_checker.sv
// Port-level checker for car_following_accel_min_top, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "car_following_accel_min_top_assert.svh"
module cfa_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] clamp_status
);
	`CFA_ASSERT_IMPL(a_status_code, out_valid, clamp_status != 2'd3)
	`CFA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
	`CFA_ASSERT_NEXT(a_status_stable, out_valid && !out_ready, $stable(clamp_status))
endmodule

bind car_following_accel_min_top cfa_checker u_chk (.clk(clk), .arst_n(arst_n),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.clamp_status(out_ch.data.clamp_status));

>>> tb/cfa_tb_if.sv
// Testbench file named for the valid/ready channel interfaces; it declares none of them.
`timescale 1ns / 1ps

>>> tb/cfa_accel_checker.sv
// Checker for the car-following acceleration block: predicts each result from accepted
// input items and compares it with the result channel. Depends on cfa_pkg.
`timescale 1ns / 1ps
module cfa_accel_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input cfa_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input cfa_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output int fail_count,
	output int pending
);
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;

	cfa_pkg::cfg_t regs;
	longint least_accel;
	bit opens_run;
	cfa_pkg::out_item_t accel_queue[$];

	function automatic longint clip(longint x);
		if (x > QMAX) return QMAX;
		if (x < QMIN) return QMIN;
		return x;
	endfunction

	// Product shifted right, magnitude rounded toward zero, then saturated.
	function automatic longint mul_shift(longint a, longint b, int sh);
		logic [127:0] p;
		logic [127:0] m;
		bit neg;
		neg = (a < 0) != (b < 0);
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		m = p >> sh;
		if (neg) return (m > 128'(QMAX) + 1) ? QMIN : -longint'(m);
		return (m > 128'(QMAX)) ? QMAX : longint'(m);
	endfunction

	function automatic longint div_q16(longint n, longint d);
		longint q;
		if (d <= 0) return QMAX;
		q = ((n < 0 ? -n : n) << 16) / d;
		if (n < 0) return (q > -QMIN) ? QMIN : -q;
		return (q > QMAX) ? QMAX : q;
	endfunction

	task automatic predict_accel(cfa_pkg::in_item_t it);
		longint v, a, r, r2, r4, c1, dv, vdv, s, q, c2, cand, acc;
		cfa_pkg::out_item_t res;
		v = longint'(it.own_velocity);
		a = longint'(regs.max_accel);
		r = mul_shift(v, longint'(regs.inv_v_max), 32);
		if (opens_run) least_accel = mul_shift(a, clip(ONE - r), 16);
		if (it.has_leader) begin
			r2 = mul_shift(r, r, 16);
			r4 = mul_shift(r2, r2, 16);
			c1 = clip(ONE - r4);
			dv = clip(v - longint'(it.leader_velocity));
			vdv = mul_shift(v, dv, 16);
			s = clip(longint'(regs.jam_distance)
				+ mul_shift(v, longint'(regs.desired_headway), 16)
				+ mul_shift(vdv, longint'(regs.inv_brake_term), 32));
			q = div_q16(s, longint'(it.leader_distance));
			c2 = clip(ONE - mul_shift(q, q, 16));
			cand = mul_shift(a, c1 < c2 ? c1 : c2, 16);
			if (cand < least_accel) least_accel = cand;
		end
		opens_run = it.last_leader;
		if (it.last_leader && !it.asleep) begin
			acc = least_accel;
			res.clamp_status = cfa_pkg::CLAMP_NONE;
			if (acc > longint'(regs.max_accel)) begin
				acc = longint'(regs.max_accel);
				res.clamp_status = cfa_pkg::CLAMP_MAX;
			end else if (acc < longint'(regs.max_decel)) begin
				acc = longint'(regs.max_decel);
				res.clamp_status = cfa_pkg::CLAMP_MIN;
			end
			res.decided_accel = 32'(acc);
			accel_queue = {accel_queue, res};
		end
	endtask

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.max_accel <= 31'd98304;
			regs.max_decel <= -32'sd196608;
			regs.jam_distance <= 31'd131072;
			regs.desired_headway <= 31'd98304;
			regs.inv_v_max <= 32'd257698037;
			regs.inv_brake_term <= 32'd1012331924;
			least_accel = 0;
			opens_run = 1;
			fail_count = 0;
			accel_queue.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready) predict_accel(in_data);
			if (out_valid && out_ready) begin
				if (accel_queue.size() == 0) begin
					report_mismatch("result with no expectation");
				end else begin
					if (out_data.decided_accel !== accel_queue[0].decided_accel)
						report_mismatch($sformatf("decided_accel got %0d want %0d",
							out_data.decided_accel, accel_queue[0].decided_accel));
					if (out_data.clamp_status !== accel_queue[0].clamp_status)
						report_mismatch($sformatf("clamp_status got %0d want %0d",
							out_data.clamp_status, accel_queue[0].clamp_status));
					void'(accel_queue.pop_front());
				end
			end
			pending = accel_queue.size();
			if (cfg_we) begin
				case (cfg_index)
					cfa_pkg::CFG_MAX_ACCEL: regs.max_accel <= cfg_data[30:0];
					cfa_pkg::CFG_MAX_DECEL: regs.max_decel <= cfg_data;
					cfa_pkg::CFG_JAM: regs.jam_distance <= cfg_data[30:0];
					cfa_pkg::CFG_HEADWAY: regs.desired_headway <= cfg_data[30:0];
					cfa_pkg::CFG_INV_VMAX: regs.inv_v_max <= cfg_data;
					cfa_pkg::CFG_INV_BRAKE: regs.inv_brake_term <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

>>> tb/testbench.sv
// Top of the car-following acceleration testbench: clock, reset, register writes and item stimulus
// with random idling; depends on cfa_pkg, cfa_if, cfa_accel_checker and car_following_accel_min_top.
`timescale 1ns / 1ps
module testbench;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = cfa_pkg::CFG_MAX_ACCEL;
	logic [31:0] cfg_data = '0;
	int fail_count;
	int pending;
	bit out_idle_enable = 1;

	cfa_in_if in_ch ();
	cfa_out_if out_ch ();

	always #4 clk = ~clk;

	car_following_accel_min_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cfa_accel_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
	end

	// The result side drops ready at random, at times for a random burst, until the final part of the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_idle_enable && !out_ch.ready && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ch.ready <= !(out_idle_enable && $urandom_range(0, 5) == 0);
		end
	end

	// One register write, one clock edge long.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offers one item and keeps it offered until ready, sampled after each rising edge, reads
	// high. The sender may first idle for a random burst; valid stays low during that gap.
	task automatic send_item(cfa_pkg::in_item_t it, bit idle_ok);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drop_valid();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	// Waits until every expected result has come and the block has had time to
	// finish the queued items that give none, so that registers can be rewritten.
	task automatic drain();
		drop_valid();
		while (pending != 0) @(posedge clk);
		repeat (320) @(posedge clk);
	endtask

	function automatic logic [31:0] rand32();
		return $urandom();
	endfunction

	// A speed in a useful range most of the time, the full 31-bit range otherwise.
	function automatic logic [30:0] rand_speed();
		case ($urandom_range(0, 3))
			0: return 31'($urandom());
			1: return 31'($urandom_range(0, 32'h0002_0000));
			default: return 31'($urandom_range(0, 32'h0028_0000));
		endcase
	endfunction

	function automatic logic [31:0] rand_gap();
		case ($urandom_range(0, 7))
			0: return rand32();
			1: return -32'($urandom_range(0, 32'h0010_0000));
			2: return '0;
			default: return 32'($urandom_range(32'h0000_4000, 32'h0100_0000));
		endcase
	endfunction

	function automatic cfa_pkg::in_item_t rand_item(bit last);
		cfa_pkg::in_item_t it;
		it.own_velocity = rand_speed();
		it.leader_distance = rand_gap();
		it.leader_velocity = ($urandom_range(0, 4) == 0) ? rand32()
			: 32'($urandom_range(0, 32'h0028_0000));
		it.has_leader = $urandom_range(0, 4) != 0;
		it.last_leader = last;
		it.asleep = $urandom_range(0, 9) == 0;
		return it;
	endfunction

	// A vehicle's run: one to four items, the last one marked.
	task automatic send_run(bit idle_ok);
		int n;
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++) send_item(rand_item(k == n - 1), idle_ok);
	endtask

	task automatic random_regs();
		write_reg(cfa_pkg::CFG_MAX_ACCEL, $urandom_range(0, 32'h0005_0000));
		write_reg(cfa_pkg::CFG_MAX_DECEL, -32'($urandom_range(0, 32'h000A_0000)));
		write_reg(cfa_pkg::CFG_JAM, $urandom_range(0, 32'h0005_0000));
		write_reg(cfa_pkg::CFG_HEADWAY, $urandom_range(0, 32'h0003_0000));
		write_reg(cfa_pkg::CFG_INV_VMAX, $urandom_range(32'h0100_0000, 32'h2000_0000));
		write_reg(cfa_pkg::CFG_INV_BRAKE, rand32());
	endtask

	initial begin
		cfa_pkg::in_item_t it;
		int items_sent;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: field extremes, free flow, zero and negative gaps, sleeping
		// vehicles, and a free-flow speed that differs from later leader speeds.
		it = '{31'd0, 32'sd65536, 32'sd0, 1'b0, 1'b1, 1'b0};
		send_item(it, 0);
		it = '{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0};
		send_item(it, 0);
		it = '{31'd655360, 32'sd0, 32'sd0, 1'b1, 1'b1, 1'b0};
		send_item(it, 0);
		it = '{31'd655360, -32'sd65536, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0};
		send_item(it, 0);
		it = '{31'd65536, 32'sd655360, 32'sd65536, 1'b1, 1'b0, 1'b0};
		send_item(it, 0);
		it = '{31'd1310720, 32'sd1310720, 32'sd0, 1'b1, 1'b0, 1'b0};
		send_item(it, 0);
		it = '{31'd196608, 32'h8000_0000, 32'sd0, 1'b0, 1'b1, 1'b0};
		send_item(it, 0);
		it = '{31'd327680, 32'sd327680, 32'sd0, 1'b1, 1'b1, 1'b1};
		send_item(it, 0);
		it = '{31'd0, 32'sd1, 32'sd0, 1'b1, 1'b1, 1'b0};
		send_item(it, 0);
		drain();

		// Extreme register settings, including values outside their nominal range
		// so that the clamp order shows.
		write_reg(cfa_pkg::CFG_MAX_ACCEL, 32'h7FFF_FFFF);
		write_reg(cfa_pkg::CFG_MAX_DECEL, 32'h8000_0000);
		write_reg(cfa_pkg::CFG_JAM, 32'h7FFF_FFFF);
		write_reg(cfa_pkg::CFG_HEADWAY, 32'h7FFF_FFFF);
		write_reg(cfa_pkg::CFG_INV_VMAX, 32'hFFFF_FFFF);
		write_reg(cfa_pkg::CFG_INV_BRAKE, 32'hFFFF_FFFF);
		write_reg(3'd7, 32'hFFFF_FFFF);
		for (int k = 0; k < 6; k++) send_run(1);
		drain();
		write_reg(cfa_pkg::CFG_MAX_ACCEL, 32'd0);
		write_reg(cfa_pkg::CFG_MAX_DECEL, 32'h7FFF_FFFF);
		write_reg(cfa_pkg::CFG_JAM, 32'd0);
		write_reg(cfa_pkg::CFG_HEADWAY, 32'd0);
		write_reg(cfa_pkg::CFG_INV_VMAX, 32'd0);
		write_reg(cfa_pkg::CFG_INV_BRAKE, 32'd0);
		for (int k = 0; k < 6; k++) send_run(1);
		drain();

		// Random part: runs with random content, settings changed between phases.
		// Idling stops in the last phase.
		items_sent = 0;
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 7) out_idle_enable = 0;
			if (phase == 0) begin
				write_reg(cfa_pkg::CFG_MAX_ACCEL, 32'd98304);
				write_reg(cfa_pkg::CFG_MAX_DECEL, -32'sd196608);
				write_reg(cfa_pkg::CFG_JAM, 32'd131072);
				write_reg(cfa_pkg::CFG_HEADWAY, 32'd98304);
				write_reg(cfa_pkg::CFG_INV_VMAX, 32'd257698037);
				write_reg(cfa_pkg::CFG_INV_BRAKE, 32'd1012331924);
			end else begin
				random_regs();
			end
			for (int k = 0; k < 60; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// Stray single item that may or may not end a run on its own.
					send_item(rand_item($urandom_range(0, 1)), phase != 7);
				end else begin
					send_run(phase != 7);
				end
			end
			// Make sure the phase ends with a closed run before the registers change.
			it = rand_item(1);
			send_item(it, phase != 7);
			drain();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
